### sv/wtm_pkg.sv
`default_nettype none
package wtm_pkg;

	// Accumulator widths, sized for the largest window of 4096 samples
	localparam int CW = 13;   // sample and gain/loss counts
	localparam int VW = 37;   // signed sum of samples
	localparam int WW = 50;   // signed sum of day * sample
	localparam int TW = 36;   // running N(N*N-1)/3
	localparam int GW = 36;   // gain or loss magnitude sum
	localparam int PW = 49;   // gain sum * loss count
	localparam int NW = 52;   // twice the slope numerator, signed
	localparam int DW = 65;   // divider operand width

	localparam logic [1:0] CAT_BULLISH    = 2'd0;
	localparam logic [1:0] CAT_BEARISH    = 2'd1;
	localparam logic [1:0] CAT_INDECISION = 2'd2;

	localparam logic [1:0] DIR_CONTINUATION = 2'd0;
	localparam logic [1:0] DIR_REVERSAL     = 2'd1;
	localparam logic [1:0] DIR_NONE         = 2'd2;

	typedef struct packed {
		logic signed [23:0] price_delta;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic [14:0]        strength_index;
		logic [1:0]         category;
		logic [1:0]         direction;
		logic               error;
	} out_item_t;

	// Closed window handed from the front to the back
	typedef struct packed {
		logic [CW-1:0]        count;
		logic signed [VW-1:0] value_sum;
		logic signed [WW-1:0] weighted_sum;
		logic [TW-1:0]        tri_sum;
		logic [GW-1:0]        gain_sum;
		logic [CW-1:0]        gain_count;
		logic [GW-1:0]        loss_sum;
		logic [CW-1:0]        loss_count;
	} window_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SUM,
		B_SLO_GO,
		B_SLO_WAIT,
		B_RSI_GO,
		B_RSI_WAIT,
		B_OUT
	} back_state_t;

endpackage
`default_nettype wire

### sv/window_trend_momentum_classifier.sv
// Window trend and momentum classifier.
// Input queue side: push with sample (price difference, last flag); an item
// is taken on a clock edge with push high and full low. One item per cycle.
// The item flagged last closes the window; only closing items give a result.
// Result queue side: result is valid while empty is low and is taken on an
// edge with pop high. A result waits in its output register while the block
// keeps loading the next window.
// From the closing item to its result the back end runs two
// product/sum stages, then one shared restoring divider run for the slope
// and one for the strength index, one bit per cycle. A window without
// both gains and losses skips the second run; an empty window skips both.
// Up to two closed windows wait between loading and the divider; when both
// are held, full rises. The back end takes the next closed window only
// once the result of the last one is loaded into its output register.
// A stalled receiver stops the back end at its output, then the queue fills
// and full stops new items. Asynchronous reset clears the front's window sums,
// the queue and the output valid flag; no clearing pass follows.
`default_nettype none
module window_trend_momentum_classifier #(
	parameter int WINDOW_MAX = 256,
	parameter int FULL_SCALE = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  wtm_pkg::in_item_t  sample,
	input  logic               pop,
	output logic               empty,
	output wtm_pkg::out_item_t result
);
	import wtm_pkg::*;

	logic    q_full;
	logic    q_push;
	logic    q_pop;
	logic    q_empty;
	window_t q_wdata;
	window_t q_rdata;

	wtm_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sample (sample),
		.q_full (q_full),
		.full   (full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	wtm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	wtm_back #(.FULL_SCALE(FULL_SCALE)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
`default_nettype wire

### sv/wtm_front.sv
`default_nettype none
module wtm_front #(
	parameter int WINDOW_MAX = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wtm_pkg::in_item_t sample,
	input  logic              q_full,
	output logic              full,
	output logic              q_push,
	output wtm_pkg::window_t  q_data
);
	import wtm_pkg::*;

	window_t            win_q;
	window_t            nxt;
	logic               accept;
	logic               take;
	logic [CW-1:0]      cnt_inc;
	logic signed [23:0] p;
	logic signed [37:0] wprod;
	logic [25:0]        tprod;
	logic [23:0]        loss_mag;

	assign accept = push & ~q_full;
	assign full   = q_full;
	assign p      = sample.price_delta;

	// Running sums for the next window state
	always_comb begin
		take     = (win_q.count < CW'(WINDOW_MAX));
		cnt_inc  = win_q.count + 1'b1;
		wprod    = $signed({1'b0, cnt_inc}) * p;
		tprod    = 26'(win_q.count) * 26'(cnt_inc);
		loss_mag = 24'(-p);
		nxt      = win_q;
		if (take) begin
			nxt.count        = cnt_inc;
			nxt.value_sum    = win_q.value_sum + VW'(p);
			nxt.weighted_sum = win_q.weighted_sum + WW'(wprod);
			nxt.tri_sum      = win_q.tri_sum + TW'(tprod);
			if (p > 0) begin
				nxt.gain_sum   = win_q.gain_sum + GW'(p[22:0]);
				nxt.gain_count = win_q.gain_count + 1'b1;
			end else if (p < 0) begin
				nxt.loss_sum   = win_q.loss_sum + GW'(loss_mag);
				nxt.loss_count = win_q.loss_count + 1'b1;
			end
		end
	end

	assign q_push = accept & sample.last;
	assign q_data = nxt;

	// Window accumulators, cleared once the window closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (accept) begin
			if (sample.last) begin
				win_q <= '0;
			end else begin
				win_q <= nxt;
			end
		end
	end

endmodule
`default_nettype wire

### sv/wtm_fifo.sv
`default_nettype none
module wtm_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wtm_pkg::window_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output wtm_pkg::window_t rdata
);
	import wtm_pkg::*;

	window_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	// Two-entry queue of closed windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

### sv/wtm_div.sv
`default_nettype none
module wtm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wtm_pkg::DW-1:0]    dividend,
	input  logic [wtm_pkg::DW-1:0]    divisor,
	output logic                      done,
	output logic [wtm_pkg::DW-1:0]    quotient
);
	import wtm_pkg::*;

	logic [DW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [6:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;

	// One quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
		diff   = {1'b0, rem_sh} - {2'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[DW+1] ? rem_sh : diff[DW:0];
			quo_q <= {quo_q[DW-2:0], ~diff[DW+1]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### sv/wtm_back.sv
`default_nettype none
module wtm_back #(
	parameter int FULL_SCALE = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  wtm_pkg::window_t   q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output wtm_pkg::out_item_t result
);
	import wtm_pkg::*;

	localparam logic [14:0] RSI_FULL = 15'(FULL_SCALE * 256);

	back_state_t        state_q;
	back_state_t        state_nxt;
	window_t            win_q;
	logic signed [NW-1:0] prod_ns_q;
	logic signed [NW-1:0] num2_q;
	logic [PW-1:0]      a_q;
	logic [PW-1:0]      b_q;
	logic [27:0]        sq_q;
	logic [TW:0]        den4_q;
	logic [PW:0]        den_r_q;
	logic [63:0]        num_fs_q;
	logic [31:0]        slope_q;
	logic [14:0]        rsi_q;
	out_item_t          res_q;
	logic               res_valid_q;
	logic [CW:0]        np1;
	logic [55:0]        afs;
	logic [NW-1:0]      mag;
	logic               div_start;
	logic               div_done;
	logic [DW-1:0]      div_dvd;
	logic [DW-1:0]      div_dvs;
	logic [DW-1:0]      div_quo;
	logic               res_load;
	logic               rsi_div;
	out_item_t          res_nxt;

	assign np1     = {1'b0, win_q.count} + 1'b1;
	assign afs     = 56'(a_q) * 56'(FULL_SCALE);
	assign mag     = num2_q[NW-1] ? NW'(-num2_q) : NW'(num2_q);
	assign rsi_div = (win_q.gain_count != '0) && (win_q.loss_count != '0);

	wtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE:     if (!q_empty) state_nxt = B_MUL;
			B_MUL:      state_nxt = B_SUM;
			B_SUM:      state_nxt = (win_q.count != '0) ? B_SLO_GO : B_OUT;
			B_SLO_GO:   state_nxt = B_SLO_WAIT;
			B_SLO_WAIT: if (div_done) state_nxt = rsi_div ? B_RSI_GO : B_OUT;
			B_RSI_GO:   state_nxt = B_RSI_WAIT;
			B_RSI_WAIT: if (div_done) state_nxt = B_OUT;
			B_OUT:      if (!res_valid_q || pop) state_nxt = B_IDLE;
			default:    state_nxt = B_IDLE;
		endcase
	end

	// Control outputs and divider operands
	always_comb begin
		q_pop     = (state_q == B_IDLE) && !q_empty;
		div_start = (state_q == B_SLO_GO) || (state_q == B_RSI_GO);
		res_load  = (state_q == B_OUT) && (!res_valid_q || pop);
		if (state_q == B_RSI_GO) begin
			div_dvd = DW'(num_fs_q) + DW'(den_r_q >> 1);
			div_dvs = DW'(den_r_q);
		end else begin
			div_dvd = DW'({mag, 9'b0}) + DW'(den4_q >> 1);
			div_dvs = DW'(den4_q);
		end
	end

	// Result assembly
	always_comb begin
		res_nxt.slope          = slope_q;
		res_nxt.strength_index = rsi_q;
		res_nxt.error          = 1'b0;
		if (win_q.count == '0) begin
			res_nxt.slope          = '0;
			res_nxt.strength_index = '0;
			res_nxt.category       = CAT_INDECISION;
			res_nxt.direction      = DIR_NONE;
			res_nxt.error          = 1'b1;
		end else if (num2_q > 0) begin
			res_nxt.category  = CAT_BULLISH;
			res_nxt.direction = (win_q.gain_count != '0) ? DIR_CONTINUATION : DIR_REVERSAL;
		end else if (num2_q < 0) begin
			res_nxt.category  = CAT_BEARISH;
			res_nxt.direction = DIR_REVERSAL;
		end else begin
			res_nxt.category  = CAT_INDECISION;
			res_nxt.direction = DIR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: products, sums, divider results
	always_ff @(posedge clk) begin
		if (q_pop) begin
			win_q <= q_data;
		end
		if (state_q == B_MUL) begin
			prod_ns_q <= $signed({1'b0, np1}) * win_q.value_sum;
			a_q       <= win_q.gain_sum * win_q.loss_count;
			b_q       <= win_q.loss_sum * win_q.gain_count;
			sq_q      <= 28'(np1) * 28'(np1);
		end
		if (state_q == B_SUM) begin
			num2_q   <= ($signed(NW'(win_q.weighted_sum)) <<< 1) - prod_ns_q;
			den4_q   <= (TW+1)'(win_q.tri_sum) + (win_q.count[0] ? (TW+1)'(sq_q) : '0);
			den_r_q  <= (PW+1)'(a_q) + (PW+1)'(b_q);
			num_fs_q <= {afs, 8'b0};
			rsi_q    <= (win_q.gain_count == '0) ? 15'd0 : RSI_FULL;
		end
		if (state_q == B_SLO_WAIT && div_done) begin
			if (num2_q[NW-1]) begin
				slope_q <= (div_quo > DW'(33'h0_8000_0000)) ? 32'h8000_0000
					: 32'(-div_quo[31:0]);
			end else begin
				slope_q <= (div_quo > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
			end
		end
		if (state_q == B_RSI_WAIT && div_done) begin
			rsi_q <= (div_quo > DW'(RSI_FULL)) ? RSI_FULL : div_quo[14:0];
		end
		if (res_load) begin
			res_q <= res_nxt;
		end
	end

	assign empty  = ~res_valid_q;
	assign result = res_q;

`ifndef SYNTH
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("window queue popped while empty");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> res_valid_q)
		else $error("result not held after load");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == B_SLO_WAIT || state_q == B_RSI_WAIT))
		else $error("divider finished outside a wait state");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !pop) |=> $stable(res_q))
		else $error("waiting result overwritten");
`endif

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import wtm_pkg::*;

	localparam int WIN_MAX   = 256;
	localparam int SCALE     = 100;
	localparam int IDLE_STOP = 20000;

	// Running sums of the window being loaded, with the expected results
	class trend_scoreboard;
		int unsigned       days_loaded;
		longint            price_sum;
		longint            day_weighted_sum;
		longint unsigned   gain_total;
		int unsigned       gain_days;
		longint unsigned   loss_total;
		int unsigned       loss_days;
		out_item_t         pending[$];
		int                fault_count;

		function void clear_window();
			days_loaded = 0;
			price_sum = 0;
			day_weighted_sum = 0;
			gain_total = 0;
			gain_days = 0;
			loss_total = 0;
			loss_days = 0;
		endfunction

		function longint unsigned strength(longint unsigned g, longint unsigned l);
			longint unsigned a, b, num, den, q;
			if (gain_days == 0)
				return 0;
			if (loss_days == 0)
				return SCALE * 256;
			a = g * loss_days;
			b = l * gain_days;
			den = a + b;
			if (den == 0)
				return 0;
			num = SCALE * 256 * a;
			q = (num + den / 2) / den;
			if (q > SCALE * 256)
				q = SCALE * 256;
			return q;
		endfunction

		// Note an accepted item; a closing item yields one expected result
		function void note_sample(in_item_t s);
			longint p, n, num2, den4;
			longint unsigned mag, q;
			out_item_t r;
			p = longint'(s.price_delta);
			if (days_loaded < WIN_MAX) begin
				days_loaded++;
				price_sum += p;
				day_weighted_sum += longint'(days_loaded) * p;
				if (p > 0) begin
					gain_total += p;
					gain_days++;
				end else if (p < 0) begin
					loss_total += -p;
					loss_days++;
				end
			end
			if (!s.last)
				return;
			n = longint'(days_loaded);
			den4 = (n * (n * n - 1)) / 3;
			if (n % 2 == 1)
				den4 += (n + 1) * (n + 1);
			if (n == 0 || den4 == 0) begin
				r = '0;
				r.category = CAT_INDECISION;
				r.direction = DIR_NONE;
				r.error = 1'b1;
			end else begin
				num2 = 2 * day_weighted_sum - (n + 1) * price_sum;
				mag = num2 < 0 ? -num2 : num2;
				q = (mag * 512 + den4 / 2) / den4;
				if (num2 < 0)
					r.slope = q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
				else
					r.slope = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(q);
				r.strength_index = 15'(strength(gain_total, loss_total));
				if (num2 > 0) begin
					r.category = CAT_BULLISH;
					r.direction = gain_days > 0 ? DIR_CONTINUATION : DIR_REVERSAL;
				end else if (num2 < 0) begin
					r.category = CAT_BEARISH;
					r.direction = DIR_REVERSAL;
				end else begin
					r.category = CAT_INDECISION;
					r.direction = DIR_NONE;
				end
				r.error = 1'b0;
			end
			pending.push_back(r);
			clear_window();
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			fault_count++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.slope !== want.slope)
				report("slope", got.slope, want.slope);
			if (got.strength_index !== want.strength_index)
				report("strength_index", got.strength_index, want.strength_index);
			if (got.category !== want.category)
				report("category", got.category, want.category);
			if (got.direction !== want.direction)
				report("direction", got.direction, want.direction);
			if (got.error !== want.error)
				report("error", got.error, want.error);
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	logic      full, empty;
	in_item_t  sample = '0;
	out_item_t result;

	trend_scoreboard sb;
	bit        sending_done = 1'b0;
	bit        hold_off = 1'b0;
	int        idle_cycles = 0;

	always #5 clk = ~clk;

	window_trend_momentum_classifier i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.pop(pop), .empty(empty), .result(result)
	);

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one item, wait until taken, then idle a random gap if gaps is set
	task send_item(logic signed [23:0] p, logic l, bit gaps);
		int g;
		push <= 1'b1;
		sample <= '{price_delta: p, last: l};
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_sample('{price_delta: p, last: l});
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function logic signed [23:0] rand_price();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 24'sh7FFFFF;
		if (r == 1)
			return 24'sh800000;
		if (r == 2)
			return 24'sh000000;
		if (r < 6)
			return 24'($urandom_range(0, 2000) - 1000);
		return 24'($urandom);
	endfunction

	task send_window(int len, int mode, bit gaps);
		logic signed [23:0] p;
		for (int i = 0; i < len; i++) begin
			case (mode)
				1: p = 24'($urandom_range(1, 8388607));
				2: p = -$signed({1'b0, 23'($urandom_range(1, 8388607))});
				3: p = 0;
				default: p = rand_price();
			endcase
			send_item(p, i == len - 1, gaps);
		end
	endtask

	// Stimulus
	initial begin
		int len, burst;
		sb = new();
		sb.clear_window();
		sb.fault_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, single sample, only gains, only losses, zero window
		send_item(24'sh7FFFFF, 1'b1, 0);
		send_item(24'sh800000, 1'b1, 0);
		send_item(24'sh000000, 1'b1, 0);
		send_window(2, 1, 0);
		send_window(3, 2, 0);
		send_window(4, 3, 0);
		send_item(24'sh800000, 1'b0, 0);
		send_item(24'sh7FFFFF, 1'b1, 0);
		send_item(24'sh7FFFFF, 1'b0, 0);
		send_item(24'sh800000, 1'b0, 0);
		send_item(24'sh000001, 1'b1, 0);
		send_window(5, 0, 0);
		// overflow: a full window of big losses then big gains, then dropped samples
		for (int i = 0; i < WIN_MAX + 5; i++)
			send_item(i < 128 ? 24'sh800000 : 24'sh7FFFFF, i == WIN_MAX + 4, 0);
		// receiver held off while the sender keeps pushing short windows;
		// the receiver lifts the hold itself once its stretch has run
		hold_off = 1'b1;
		repeat (60) send_window($urandom_range(1, 3), 0, 0);
		// random windows, mostly short
		burst = 0;
		while (burst < 1300) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
			send_window(len, $urandom_range(0, 7) < 2 ? $urandom_range(1, 3) : 0,
				$urandom_range(0, 3) != 0);
			burst += len;
		end
		push <= 1'b0;
		sending_done = 1'b1;
	end

	// Receiver: random pops, a long hold-off on request
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				pop <= 1'b0;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				pop <= 1'b0;
				repeat (g) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	// Result checking and the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(result);
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0 && idle_cycles < IDLE_STOP)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.pending.size() == 0 && sb.fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		wait (idle_cycles >= IDLE_STOP);
		$display("timeout");
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
